### hw/rtl/uffmw_pkg.sv
// ----------------------------------------------------------------------------
// uffmw_pkg: shared constants and types of the maze wall decider
// Grid sizes, cell indexing widths and the parent table request bundle.
// ----------------------------------------------------------------------------
package uffmw_pkg;

  localparam int MAX_ROW   = 32;
  localparam int MAX_COL   = 22;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 5;

  localparam int CELL_ROWS = MAX_ROW / 2 + 1;
  localparam int CELL_COLS = MAX_COL / 2 + 1;
  localparam int NUM_CELLS = CELL_ROWS * CELL_COLS;
  localparam int IDX_W     = $clog2(NUM_CELLS);

  typedef logic [IDX_W-1:0] idx_t;

  // One cycle's access to the parent table: one write port, one read port.
  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    logic re;
    idx_t raddr;
  } ram_req_t;

endpackage

### hw/rtl/uffmw_if.sv
// ----------------------------------------------------------------------------
// uffmw_if: request channels of the maze wall decider
// Wall request channel in, decision channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface uffmw_wall_if;
  logic                          valid;
  logic                          ready;
  logic [uffmw_pkg::ROW_W-1:0]   wall_row;
  logic [uffmw_pkg::COL_W-1:0]   wall_col;

  modport source (output valid, output wall_row, output wall_col, input ready);
  modport sink   (input valid, input wall_row, input wall_col, output ready);
endinterface

interface uffmw_result_if;
  logic                          valid;
  logic                          ready;
  logic                          open;
  logic [uffmw_pkg::ROW_W-1:0]   out_row;
  logic [uffmw_pkg::COL_W-1:0]   out_col;

  modport source (output valid, output open, output out_row, output out_col, input ready);
  modport sink   (input valid, input open, input out_row, input out_col, output ready);
endinterface

### hw/rtl/uffmw_parent_ram.sv
// ----------------------------------------------------------------------------
// uffmw_parent_ram: parent table of the union-find forest
// One write and one registered read per cycle. A per-entry valid bit makes
// an entry that was never written read back as its own index.
// ----------------------------------------------------------------------------
module uffmw_parent_ram (
  input  logic                clk,
  input  logic                rst,
  input  uffmw_pkg::ram_req_t req,
  output uffmw_pkg::idx_t     rd_data
);

  uffmw_pkg::idx_t                   mem [uffmw_pkg::NUM_CELLS];
  logic [uffmw_pkg::NUM_CELLS-1:0]   written;
  uffmw_pkg::idx_t                   mem_q;
  uffmw_pkg::idx_t                   addr_q;
  logic                              written_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q  <= mem[req.raddr];
      addr_q <= req.raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        written_q <= written[req.raddr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : addr_q;

endmodule

### hw/rtl/uffmw_seq.sv
// ----------------------------------------------------------------------------
// uffmw_seq: sequencer of the wall decider
// Decodes the wall, walks both parent chains to their roots, compresses
// both chains, links the roots and holds the decision in an output register.
// ----------------------------------------------------------------------------
module uffmw_seq (
  input  logic                  clk,
  input  logic                  rst,
  uffmw_wall_if.sink            wall,
  uffmw_result_if.source        result,
  output uffmw_pkg::ram_req_t   req,
  input  uffmw_pkg::idx_t       rd_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIND_A = 3'd1;
  localparam logic [2:0] ST_FIND_B = 3'd2;
  localparam logic [2:0] ST_COMP_A = 3'd3;
  localparam logic [2:0] ST_COMP_B = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam int ROW_W = uffmw_pkg::ROW_W;
  localparam int COL_W = uffmw_pkg::COL_W;
  localparam int IDX_W = uffmw_pkg::IDX_W;

  logic [2:0]                state, state_next;
  uffmw_pkg::idx_t           x, x_next;
  uffmw_pkg::idx_t           ra, ra_next;
  uffmw_pkg::idx_t           rb, rb_next;
  uffmw_pkg::idx_t           a, b;
  logic                      res_open, res_open_next;
  logic [ROW_W-1:0]          row_q;
  logic [COL_W-1:0]          col_q;
  logic                      accept;
  logic                      out_load;
  logic                      pos_ok;
  uffmw_pkg::idx_t           a_in, b_in;
  uffmw_pkg::idx_t           p;

  assign p          = rd_data;
  assign wall.ready = (state == ST_IDLE);
  assign accept     = wall.valid && wall.ready;

  // Exactly one coordinate odd, inside the grid, with both neighbors inside.
  always_comb begin
    pos_ok = 1'b1;
    if (wall.wall_row > ROW_W'(uffmw_pkg::MAX_ROW) ||
        wall.wall_col > COL_W'(uffmw_pkg::MAX_COL)) begin
      pos_ok = 1'b0;
    end else if (wall.wall_row[0] == wall.wall_col[0]) begin
      pos_ok = 1'b0;
    end else if (wall.wall_row[0] && wall.wall_row == ROW_W'(uffmw_pkg::MAX_ROW)) begin
      pos_ok = 1'b0;
    end else if (wall.wall_col[0] && wall.wall_col == COL_W'(uffmw_pkg::MAX_COL)) begin
      pos_ok = 1'b0;
    end
  end

  // The upper or left cell sits at (row/2, col/2) in both orientations.
  assign a_in = IDX_W'(wall.wall_row[ROW_W-1:1]) * IDX_W'(uffmw_pkg::CELL_COLS)
              + IDX_W'(wall.wall_col[COL_W-1:1]);
  assign b_in = a_in + (wall.wall_row[0] ? IDX_W'(uffmw_pkg::CELL_COLS) : IDX_W'(1));

  always_comb begin
    state_next    = state;
    x_next        = x;
    ra_next       = ra;
    rb_next       = rb;
    res_open_next = res_open;
    out_load      = 1'b0;
    req           = '0;
    unique case (state)
      ST_IDLE: begin
        if (wall.valid) begin
          if (pos_ok) begin
            x_next     = a_in;
            req.re     = 1'b1;
            req.raddr  = a_in;
            state_next = ST_FIND_A;
          end else begin
            res_open_next = 1'b0;
            state_next    = ST_DONE;
          end
        end
      end
      ST_FIND_A: begin
        if (p == x) begin
          ra_next    = x;
          x_next     = b;
          req.re     = 1'b1;
          req.raddr  = b;
          state_next = ST_FIND_B;
        end else begin
          x_next    = p;
          req.re    = 1'b1;
          req.raddr = p;
        end
      end
      ST_FIND_B: begin
        if (p == x) begin
          rb_next    = x;
          x_next     = a;
          req.re     = 1'b1;
          req.raddr  = a;
          state_next = ST_COMP_A;
        end else begin
          x_next    = p;
          req.re    = 1'b1;
          req.raddr = p;
        end
      end
      ST_COMP_A: begin
        if (x == ra) begin
          x_next     = b;
          req.re     = 1'b1;
          req.raddr  = b;
          state_next = ST_COMP_B;
        end else begin
          // Point this cell at its root and step to its old parent.
          req.we    = 1'b1;
          req.waddr = x;
          req.wdata = ra;
          x_next    = p;
          req.re    = 1'b1;
          req.raddr = p;
        end
      end
      ST_COMP_B: begin
        if (x == rb) begin
          if (ra != rb) begin
            req.we    = 1'b1;
            req.waddr = ra;
            req.wdata = rb;
          end
          res_open_next = (ra != rb);
          state_next    = ST_DONE;
        end else begin
          req.we    = 1'b1;
          req.waddr = x;
          req.wdata = rb;
          x_next    = p;
          req.re    = 1'b1;
          req.raddr = p;
        end
      end
      ST_DONE: begin
        if (!result.valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x        <= x_next;
    ra       <= ra_next;
    rb       <= rb_next;
    res_open <= res_open_next;
    if (accept) begin
      row_q <= wall.wall_row;
      col_q <= wall.wall_col;
      a     <= a_in;
      b     <= b_in;
    end
    if (out_load) begin
      result.open    <= res_open;
      result.out_row <= row_q;
      result.out_col <= col_q;
    end
  end

  // A compression write never lands on the address being read in that cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req.we && req.re) |-> (req.waddr != req.raddr))
    else $error("uffmw_seq: parent write collides with read");

  // Every write stays inside the table.
  assert property (@(posedge clk) disable iff (rst)
    req.we |-> (req.waddr < IDX_W'(uffmw_pkg::NUM_CELLS)))
    else $error("uffmw_seq: parent write out of range");

  // An opened wall always joined two distinct roots.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_open) |-> (ra != rb))
    else $error("uffmw_seq: wall opened inside one set");

  // The table is written only while compressing or linking.
  assert property (@(posedge clk) disable iff (rst)
    req.we |-> (state == ST_COMP_A || state == ST_COMP_B))
    else $error("uffmw_seq: parent write outside compression");

endmodule

### hw/rtl/union_find_maze_wall_decider_unit.sv
// ----------------------------------------------------------------------------
// union_find_maze_wall_decider_unit: union-find core of spanning-tree maze building
// Decides for each candidate wall whether it opens into a passage.
// ----------------------------------------------------------------------------
// Usage:
//   The wall channel takes one request per wall (wall_row, wall_col), in the
//   order the walls are to be tried. The result channel returns one decision
//   per request: open, with the wall position echoed.
//   Each request walks the parent chain of both cells to the root, then walks
//   both chains again, pointing every cell straight at its root, and links
//   the roots when they differ. The chain walks are paced by the single read
//   port of the parent table (one chain step per cycle). Walls that are no
//   wall (cell, post or off-grid position) return open = 0.
//   wall.ready is high only while the sequencer is idle; one request is in
//   work at a time.
//   The decision sits in an output register: a stalled receiver blocks only
//   the next result, and the next request is accepted meanwhile.
//   Reset makes every cell its own root at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module union_find_maze_wall_decider_unit (
  input  logic            clk,
  input  logic            rst,
  uffmw_wall_if.sink      wall,
  uffmw_result_if.source  result
);

  uffmw_pkg::ram_req_t  req;
  uffmw_pkg::idx_t      rd_data;

  uffmw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .wall    (wall),
    .result  (result),
    .req     (req),
    .rd_data (rd_data)
  );

  uffmw_parent_ram u_parent_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

### sim/union_find_maze_wall_decider_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// union_find_maze_wall_decider_unit_tb: self-checking bench for the wall decider
// Drives wall requests (directed corner cases, then random walls, runs along
// rows and columns, and off-grid noise) under random idling on both channels.
// A scoreboard keeps its own parent table, predicts every decision and checks
// each one in order against what the block returns.
// ----------------------------------------------------------------------------
module union_find_maze_wall_decider_unit_tb;

  localparam int WALL_TARGET = 1150;
  localparam int QUIET_TAIL  = 150;
  localparam int DRAIN_WAIT  = 40;
  localparam int MAX_BURST   = 11;
  localparam int MAX_REPORTS = 10;

  typedef logic [uffmw_pkg::ROW_W-1:0] row_t;
  typedef logic [uffmw_pkg::COL_W-1:0] col_t;

  typedef struct {
    logic open;
    row_t row;
    col_t col;
  } decision_t;

  class decision_board;
    uffmw_pkg::idx_t parent[uffmw_pkg::NUM_CELLS];
    decision_t       awaited[$];
    int              failures;

    function new();
      for (int i = 0; i < uffmw_pkg::NUM_CELLS; i++) parent[i] = uffmw_pkg::idx_t'(i);
      failures = 0;
    endfunction

    function uffmw_pkg::idx_t cell_at(int r, int c);
      return uffmw_pkg::idx_t'((r / 2) * uffmw_pkg::CELL_COLS + c / 2);
    endfunction

    function uffmw_pkg::idx_t root_of_cell(uffmw_pkg::idx_t x);
      int steps;
      steps = 0;
      while (steps < uffmw_pkg::NUM_CELLS && parent[x] != x) begin
        x = parent[x];
        steps++;
      end
      return x;
    endfunction

    // Points every cell on the chain from x straight at its root.
    function void flatten_chain(uffmw_pkg::idx_t x, uffmw_pkg::idx_t root);
      uffmw_pkg::idx_t nx;
      int              steps;
      steps = 0;
      while (steps < uffmw_pkg::NUM_CELLS && x != root) begin
        nx = parent[x];
        parent[x] = root;
        x = nx;
        steps++;
      end
    endfunction

    function void note_wall(row_t row, col_t col);
      decision_t       d;
      uffmw_pkg::idx_t a, b, ra, rb;
      int              r, c;
      bit              is_wall;
      r = row;
      c = col;
      is_wall = !(r > uffmw_pkg::MAX_ROW || c > uffmw_pkg::MAX_COL) &&
                (((r ^ c) & 1) != 0) &&
                !((r & 1) && r + 1 > uffmw_pkg::MAX_ROW) &&
                !((c & 1) && c + 1 > uffmw_pkg::MAX_COL);
      d.open = 1'b0;
      d.row  = row;
      d.col  = col;
      if (is_wall) begin
        if (r & 1) begin
          a = cell_at(r - 1, c);
          b = cell_at(r + 1, c);
        end else begin
          a = cell_at(r, c - 1);
          b = cell_at(r, c + 1);
        end
        ra = root_of_cell(a);
        rb = root_of_cell(b);
        flatten_chain(a, ra);
        flatten_chain(b, rb);
        if (ra != rb) begin
          parent[ra] = rb;
          d.open = 1'b1;
        end
      end
      awaited.insert(awaited.size(), d);
    endfunction

    function void check_decision(logic open, row_t row, col_t col);
      decision_t d;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected decision open=%0b wall (%0d,%0d)", $time, open, row, col);
        return;
      end
      d = awaited.pop_front();
      if (open !== d.open || row !== d.row || col !== d.col) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: decision mismatch: expected open=%0b (%0d,%0d), got open=%0b (%0d,%0d)",
                   $time, d.open, d.row, d.col, open, row, col);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  uffmw_wall_if   wall_ch();
  uffmw_result_if result_ch();

  union_find_maze_wall_decider_unit dut (
    .clk    (clk),
    .rst    (rst),
    .wall   (wall_ch),
    .result (result_ch)
  );

  decision_board sb = new();

  int gap_pct   = 0;
  int stall_pct = 0;
  int walls_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side: ready drops in bursts at the current stall rate.
  initial begin
    int n;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, MAX_BURST);
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_decision(result_ch.open, result_ch.out_row, result_ch.out_col);
  end

  // Holds the request until accepted. Valid is only lowered by an idle gap
  // or at the end, so back-to-back requests keep it high.
  task automatic send_wall(int row, int col);
    int n;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, MAX_BURST);
      wall_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    wall_ch.valid    <= 1'b1;
    wall_ch.wall_row <= row_t'(row);
    wall_ch.wall_col <= col_t'(col);
    do @(posedge clk); while (!wall_ch.ready);
    sb.note_wall(row_t'(row), col_t'(col));
    walls_sent++;
  endtask

  task automatic send_random_wall();
    if ($urandom_range(0, 1))
      send_wall($urandom_range(0, (uffmw_pkg::MAX_ROW - 1) / 2) * 2 + 1,
                $urandom_range(0, uffmw_pkg::MAX_COL / 2) * 2);
    else
      send_wall($urandom_range(0, uffmw_pkg::MAX_ROW / 2) * 2,
                $urandom_range(0, (uffmw_pkg::MAX_COL - 1) / 2) * 2 + 1);
  endtask

  // A run of neighboring walls along one row or column. Going in order
  // links each root under the next and builds long parent chains.
  task automatic send_wall_run();
    int len, start, line_pos, k;
    bit along_row, forward;
    along_row = $urandom_range(0, 1);
    forward   = $urandom_range(0, 3) != 0;
    if (along_row) begin
      line_pos = $urandom_range(0, uffmw_pkg::MAX_ROW / 2) * 2;
      len      = $urandom_range(3, (uffmw_pkg::MAX_COL - 1) / 2 + 1);
      start    = $urandom_range(0, (uffmw_pkg::MAX_COL - 1) / 2 + 1 - len);
    end else begin
      line_pos = $urandom_range(0, uffmw_pkg::MAX_COL / 2) * 2;
      len      = $urandom_range(3, (uffmw_pkg::MAX_ROW - 1) / 2 + 1);
      start    = $urandom_range(0, (uffmw_pkg::MAX_ROW - 1) / 2 + 1 - len);
    end
    for (int i = 0; i < len; i++) begin
      k = forward ? start + i : start + len - 1 - i;
      if (along_row) send_wall(line_pos, 2 * k + 1);
      else           send_wall(2 * k + 1, line_pos);
    end
  endtask

  initial begin
    int kind, next_switch;
    rst <= 1'b1;
    wall_ch.valid    <= 1'b0;
    wall_ch.wall_row <= '0;
    wall_ch.wall_col <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Cells, posts and off-grid positions are echoed closed.
    send_wall(0, 0);
    send_wall(1, 1);
    send_wall(uffmw_pkg::MAX_ROW, uffmw_pkg::MAX_COL);
    send_wall(63, 31);
    send_wall(33, 0);
    send_wall(uffmw_pkg::MAX_ROW + 1, 1);
    send_wall(0, 31);
    send_wall(1, uffmw_pkg::MAX_COL + 1);
    send_wall(42, 21);
    // Real walls, most of them at the grid edges and corners.
    send_wall(0, 1);
    send_wall(1, 0);
    send_wall(2, 1);
    send_wall(1, 2);     // closes a loop: cells already joined
    send_wall(0, 1);     // the same wall again
    send_wall(uffmw_pkg::MAX_ROW - 1, uffmw_pkg::MAX_COL);
    send_wall(uffmw_pkg::MAX_ROW, uffmw_pkg::MAX_COL - 1);
    send_wall(21, 10);
    send_wall(uffmw_pkg::MAX_ROW - 1, 0);
    send_wall(0, uffmw_pkg::MAX_COL - 1);
    send_wall(uffmw_pkg::MAX_ROW, 1);
    send_wall(1, uffmw_pkg::MAX_COL);

    next_switch = 0;
    while (walls_sent < WALL_TARGET) begin
      if (walls_sent >= WALL_TARGET - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (walls_sent >= next_switch) begin
        next_switch = walls_sent + $urandom_range(40, 120);
        case ($urandom_range(0, 3))
          0: begin
            gap_pct   = 0;
            stall_pct = 0;
          end
          1: begin
            gap_pct   = 30;
            stall_pct = 5;
          end
          2: begin
            gap_pct   = 5;
            stall_pct = 30;
          end
          default: begin
            gap_pct   = $urandom_range(5, 40);
            stall_pct = $urandom_range(5, 40);
          end
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_random_wall();
      end else if (kind < 85) begin
        send_wall_run();
      end else begin
        send_wall($urandom_range(0, 63), $urandom_range(0, 31));
      end
    end

    wall_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/uffmw_pkg.sv
hw/rtl/uffmw_if.sv
hw/rtl/uffmw_parent_ram.sv
hw/rtl/uffmw_seq.sv
hw/rtl/union_find_maze_wall_decider_unit.sv
sim/union_find_maze_wall_decider_unit_tb.sv
